>>> rtl/svb_pkg.sv
// ----------------------------------------------------------------------------
// svb_pkg: shared definitions for the sawtooth voice bank
// Holds the voice count, command codes, controller states and the
// note-to-increment conversion used by the top level.
// ----------------------------------------------------------------------------
package svb_pkg;

  // Number of voices and the width of a voice index.
  localparam int VOICES  = 64;
  localparam int VOICE_W = (VOICES > 1) ? $clog2(VOICES) : 1;

  // Field and store widths.
  localparam int PHASE_W = 32;
  localparam int SUM_W   = 34;

  // Request commands.
  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_ON   = 2'd1,
    CMD_OFF  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  // Phase increments for the top octave, notes 116 to 127.
  localparam logic [PHASE_W-1:0] TOP_OCTAVE_INC [12] = '{
    32'd647154682,  32'd685636502,  32'd726406570,  32'd769600953,
    32'd815363807,  32'd863847862,  32'd915214929,  32'd969636440,
    32'd1027294023, 32'd1088380105, 32'd1153098554, 32'd1221665362
  };

  // Quotient by twelve for values up to 131, by reciprocal multiplication.
  function automatic logic [3:0] div12(input logic [7:0] m);
    logic [15:0] prod;
    prod  = 16'(m) * 16'd171;
    div12 = prod[14:11];
  endfunction

  // Increment for a MIDI note: table entry by semitone, shifted by octave.
  function automatic logic [PHASE_W-1:0] inc_for_note(input logic [6:0] n);
    logic [7:0] m;
    logic [3:0] q;
    logic [7:0] r;
    logic [3:0] oct;
    m   = 8'(n) + 8'd4;
    q   = div12(m);
    r   = m - 8'(q) * 8'd12;
    oct = div12(8'(7'd127 - n));
    inc_for_note = TOP_OCTAVE_INC[r[3:0]] >> oct;
  endfunction

endpackage

>>> rtl/svb_ram.sv
// ----------------------------------------------------------------------------
// svb_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module svb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/sawtooth_voice_bank_top.sv
// ----------------------------------------------------------------------------
// sawtooth_voice_bank_top: bank of sawtooth phase accumulators
// Holds the increment and phase of every voice in two RAMs and sums the
// active voices one per cycle on each sample tick.
// ----------------------------------------------------------------------------
// Usage.
// The request channel (req_valid, req_ready, cmd, voice, note) carries
// voice-on, voice-off and sample-tick requests. A voice-on or voice-off
// request is taken while idle and returns nothing. A tick request starts
// a scan over the voices: one RAM read is issued per cycle, and each
// active voice adds its signed phase shifted right by four to the sum and
// writes its advanced phase back. A tick therefore occupies the block
// through the scan, drain and done states, as the phase and increment
// RAMs each have a single read port; the result appears on the result
// channel (res_valid, res_ready, sample_sum) when the block leaves the
// done state, and the next tick is taken only once the block is idle.
// The result sits in an output register, so the block takes further
// requests while it waits. If the receiver stalls and a second tick
// finishes, that tick holds until the register is free.
// Reset clears per-voice written flags, so every voice reads as off with
// zero phase; no clearing pass is needed and requests are taken at once.
// ----------------------------------------------------------------------------
module sawtooth_voice_bank_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  logic [1:0]                cmd,
  input  logic [5:0]                voice,
  input  logic [6:0]                note,
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic signed [svb_pkg::SUM_W-1:0] sample_sum
);

  import svb_pkg::*;

  state_t state, state_next;

  logic [VOICE_W-1:0] scan_cnt;
  logic               pend;
  logic [VOICE_W-1:0] pend_addr;
  logic [VOICES-1:0]  ent_valid;
  logic [SUM_W-1:0]   acc;

  logic               req_fire;
  logic               voice_ok;
  logic               cfg_write;
  logic [VOICE_W-1:0] voice_idx;
  logic               scan_start;
  logic               last_issue;
  logic               res_load;

  logic               inc_we;
  logic [VOICE_W-1:0] inc_waddr;
  logic [PHASE_W-1:0] inc_wdata;
  logic [PHASE_W-1:0] inc_rdata;
  logic               ph_we;
  logic [VOICE_W-1:0] ph_waddr;
  logic [PHASE_W-1:0] ph_wdata;
  logic [PHASE_W-1:0] ph_rdata;

  logic [PHASE_W-1:0] cur_inc;
  logic [PHASE_W-1:0] cur_phase;
  logic               cur_active;
  logic [SUM_W-1:0]   term;

  // Request decode.
  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign voice_idx = VOICE_W'(voice);
  assign voice_ok  = (9'(voice) < 9'(VOICES));
  assign cfg_write = req_fire && voice_ok &&
                     ((cmd == CMD_ON) || (cmd == CMD_OFF));

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and scan controls.
  always_comb begin
    state_next = state;
    scan_start = 1'b0;
    last_issue = 1'b0;
    res_load   = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_fire && (cmd == CMD_TICK)) begin
          scan_start = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_cnt == VOICE_W'(VOICES - 1)) begin
          last_issue = 1'b1;
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!res_valid || res_ready) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Read issue counter and the stage that follows the RAM read.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
      pend     <= 1'b0;
    end else begin
      pend <= (state == S_SCAN);
      if (scan_start || last_issue) begin
        scan_cnt <= '0;
      end else if (state == S_SCAN) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= scan_cnt;
  end

  // Entries never written since reset read as off with zero phase.
  assign cur_inc    = ent_valid[pend_addr] ? inc_rdata : '0;
  assign cur_phase  = ent_valid[pend_addr] ? ph_rdata : '0;
  assign cur_active = pend && (cur_inc != '0);
  assign term       = {{(SUM_W - PHASE_W + 4){cur_phase[PHASE_W-1]}},
                       cur_phase[PHASE_W-1:4]};

  // Written flags per voice.
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
    end else if (cfg_write) begin
      ent_valid[voice_idx] <= 1'b1;
    end
  end

  // Sum of the active voices.
  always_ff @(posedge clk) begin
    if (scan_start) begin
      acc <= '0;
    end else if (cur_active) begin
      acc <= acc + term;
    end
  end

  // Increment store writes come only from voice-on and voice-off requests.
  assign inc_we    = cfg_write;
  assign inc_waddr = voice_idx;
  assign inc_wdata = (cmd == CMD_ON) ? inc_for_note(note) : '0;

  // Phase store: zeroed on first write of a voice, advanced during a scan.
  always_comb begin
    if (state == S_IDLE) begin
      ph_we    = cfg_write && !ent_valid[voice_idx];
      ph_waddr = voice_idx;
      ph_wdata = '0;
    end else begin
      ph_we    = cur_active;
      ph_waddr = pend_addr;
      ph_wdata = cur_phase + cur_inc;
    end
  end

  svb_ram #(
    .WIDTH (PHASE_W),
    .DEPTH (VOICES)
  ) u_inc_ram (
    .clk   (clk),
    .we    (inc_we),
    .waddr (inc_waddr),
    .wdata (inc_wdata),
    .raddr (scan_cnt),
    .rdata (inc_rdata)
  );

  svb_ram #(
    .WIDTH (PHASE_W),
    .DEPTH (VOICES)
  ) u_phase_ram (
    .clk   (clk),
    .we    (ph_we),
    .waddr (ph_waddr),
    .wdata (ph_wdata),
    .raddr (scan_cnt),
    .rdata (ph_rdata)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      sample_sum <= signed'(acc);
    end
  end

endmodule
